### rtl/tdbm_pkg.sv
// Shared types and constants for the two-wire display bus master.
`default_nettype none

package tdbm_pkg;

   // Request kinds carried on the request tuser.
   localparam logic [1:0] REQ_NONE  = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;
   localparam logic [1:0] REQ_STOP  = 2'd3;

   localparam int unsigned BITS_PER_BYTE = 8;
   localparam int unsigned BIT_IDX_W     = $clog2(BITS_PER_BYTE);
   localparam int unsigned QUARTER_W     = 16;
   localparam logic [QUARTER_W-1:0] QUARTER_RESET = 16'd16000;

   // Line sequencer phases, one-hot.
   typedef enum logic [11:0] {
      PH_IDLE          = 12'b0000_0000_0001,
      PH_START_HOLD    = 12'b0000_0000_0010,
      PH_BIT_CLK_LOW   = 12'b0000_0000_0100,
      PH_BIT_DATA      = 12'b0000_0000_1000,
      PH_BIT_CLK_HIGH  = 12'b0000_0001_0000,
      PH_ACK_CLK_LOW   = 12'b0000_0010_0000,
      PH_ACK_CLK_HIGH  = 12'b0000_0100_0000,
      PH_ACK_SAMPLE    = 12'b0000_1000_0000,
      PH_STOP_CLK_LOW  = 12'b0001_0000_0000,
      PH_STOP_DIO_LOW  = 12'b0010_0000_0000,
      PH_STOP_CLK_HIGH = 12'b0100_0000_0000,
      PH_STOP_DIO_HIGH = 12'b1000_0000_0000
   } phase_type;

   // One result word; clk_release lands in the lowest bit when packed.
   typedef struct packed {
      logic ack_bit;
      logic ack_valid;
      logic busy;
      logic dio_release;
      logic clk_release;
   } result_type;

endpackage

`default_nettype wire

### rtl/two_wire_display_bus_master.sv
// Top level of the two-wire display bus master: sequencer plus result skid stage.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tuser: kind; tdata: data_byte, dio_in
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: clk, dio, busy, ack_valid, ack_bit
//  csr     | in  | csr_wr_en             | csr_wr_data: quarter period in request words
//
// One request word is one sequencer step, accepted every cycle while the skid is
// empty; its result is registered in the output register, or the skid on a stall.
// The sequencer state update is a single pass of logic per accepted word.
// Reset is synchronous; all lines come out of reset released, sequencer idle.
// A stalled result side fills a one-word skid register; req_tready drops
// only while that skid register is occupied.
`default_nettype none

module two_wire_display_bus_master (
   input  wire logic        clock,
   input  wire logic        reset,
   // request
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // [7:0] data_byte, [8] dio_in, [15:9] zero
   input  wire logic [1:0]  req_tuser,  // [1:0] req_type
   // response
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // [0] clk_release, [1] dio_release,
                                        // [2] busy_res, [3] ack_valid, [4] ack_bit
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [tdbm_pkg::QUARTER_W-1:0] csr_wr_data
);
   import tdbm_pkg::*;

   result_type res_word;
   result_type out_data_ff, skid_data_ff;
   logic       out_valid_ff, skid_valid_ff;
   logic       req_accept;
   logic       out_free;

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   tdbm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .req_kind    (req_tuser),
      .data_byte   (req_tdata[7:0]),
      .dio_sample  (req_tdata[8]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (res_word)
   );

   // output register with one-word skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= req_accept;
         end
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else if (req_accept) begin
            out_data_ff <= res_word;
         end
      end else if (req_accept) begin
         skid_data_ff <= res_word;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_data_ff};

`ifndef SYNTHESIS
   // skid word only exists behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held with empty output register");

   // a word accepted against a stalled output goes to the skid register
   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (req_accept && out_valid_ff && !rsp_tready) |=> skid_valid_ff)
      else $error("accepted word lost on stalled output");

   // output drains when taken with nothing behind it
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !skid_valid_ff && !req_accept) |=> !rsp_tvalid)
      else $error("result repeated after it was taken");

   // an acknowledge is only sampled inside a running sequence
   a_ack_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[3]) |-> rsp_tdata[2])
      else $error("acknowledge reported while idle");
`endif

endmodule

`default_nettype wire

### rtl/tdbm_seq.sv
// Line sequencer: phase, bit and quarter-period timing for each accepted word.
`default_nettype none

module tdbm_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [1:0]                    req_kind,
   input  wire logic [7:0]                    data_byte,
   input  wire logic                          dio_sample,
   input  wire logic                          csr_wr_en,
   input  wire logic [tdbm_pkg::QUARTER_W-1:0] csr_wr_data,
   output tdbm_pkg::result_type               result
);
   import tdbm_pkg::*;

   logic [QUARTER_W-1:0] quarter_ff;
   phase_type            phase_ff, phase_in;
   logic [BIT_IDX_W-1:0] bit_ff, bit_in;
   logic [7:0]           shift_ff, shift_in;
   logic [QUARTER_W-1:0] tick_ff, tick_in;
   logic [2:0]           qstep_ff, qstep_in;
   logic                 clk_lvl_ff, clk_lvl_in;
   logic                 dio_lvl_ff, dio_lvl_in;

   logic [QUARTER_W-1:0] quarter_len;
   logic [QUARTER_W:0]   tick_sum;
   logic [2:0]           seg_len;
   logic                 enter;
   phase_type            target;
   logic                 sampled;

   // A zero length acts as a quarter length of one
   assign quarter_len = (quarter_ff == '0) ? {{(QUARTER_W-1){1'b0}}, 1'b1} : quarter_ff;

   // Next state of the bus sequencer for the current word
   always_comb begin
      phase_in   = phase_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      tick_in    = tick_ff;
      qstep_in   = qstep_ff;
      clk_lvl_in = clk_lvl_ff;
      dio_lvl_in = dio_lvl_ff;
      enter      = 1'b0;
      target     = PH_IDLE;
      sampled    = 1'b0;
      tick_sum   = {1'b0, tick_ff} + {{QUARTER_W{1'b0}}, 1'b1};
      seg_len    = ((phase_ff == PH_BIT_CLK_LOW) || (phase_ff == PH_BIT_DATA)) ? 3'd1 : 3'd2;

      // timed step in progress
      if (phase_ff != PH_IDLE) begin
         if (tick_sum >= {1'b0, quarter_len}) begin
            tick_in  = '0;
            qstep_in = qstep_ff + 3'd1;
         end else begin
            tick_in = tick_sum[QUARTER_W-1:0];
         end
         if (qstep_in >= seg_len) begin
            enter = 1'b1;
            case (phase_ff)
               PH_BIT_CLK_LOW:   target = PH_BIT_DATA;
               PH_BIT_DATA:      target = PH_BIT_CLK_HIGH;
               PH_BIT_CLK_HIGH: begin
                  if (bit_ff >= BIT_IDX_W'(BITS_PER_BYTE - 1)) begin
                     target = PH_ACK_CLK_LOW;
                  end else begin
                     bit_in   = bit_ff + {{(BIT_IDX_W-1){1'b0}}, 1'b1};
                     shift_in = shift_ff >> 1;
                     target   = PH_BIT_CLK_LOW;
                  end
               end
               PH_ACK_CLK_LOW:   target = PH_ACK_CLK_HIGH;
               PH_ACK_CLK_HIGH:  target = PH_ACK_SAMPLE;
               PH_STOP_CLK_LOW:  target = PH_STOP_DIO_LOW;
               PH_STOP_DIO_LOW:  target = PH_STOP_CLK_HIGH;
               PH_STOP_CLK_HIGH: target = PH_STOP_DIO_HIGH;
               default: begin
                  enter    = 1'b0;
                  phase_in = PH_IDLE;
                  tick_in  = '0;
                  qstep_in = '0;
               end
            endcase
         end
         // stray codes fall back to idle
         if ((phase_ff != PH_START_HOLD) && (phase_ff != PH_BIT_CLK_LOW) &&
             (phase_ff != PH_BIT_DATA) && (phase_ff != PH_BIT_CLK_HIGH) &&
             (phase_ff != PH_ACK_CLK_LOW) && (phase_ff != PH_ACK_CLK_HIGH) &&
             (phase_ff != PH_ACK_SAMPLE) && (phase_ff != PH_STOP_CLK_LOW) &&
             (phase_ff != PH_STOP_DIO_LOW) && (phase_ff != PH_STOP_CLK_HIGH) &&
             (phase_ff != PH_STOP_DIO_HIGH)) begin
            enter    = 1'b0;
            phase_in = PH_IDLE;
            tick_in  = '0;
            qstep_in = '0;
         end
      end

      // new command, taken only when idle (also in the cycle a sequence ends)
      if ((phase_in == PH_IDLE) && !enter && (req_kind != REQ_NONE)) begin
         enter = 1'b1;
         case (req_kind)
            REQ_START: target = PH_START_HOLD;
            REQ_WRITE: begin
               shift_in = data_byte;
               bit_in   = '0;
               target   = PH_BIT_CLK_LOW;
            end
            REQ_STOP:  target = PH_STOP_CLK_LOW;
            default:   enter  = 1'b0;
         endcase
      end

      // phase entry: restart timing and apply the line action
      if (enter) begin
         phase_in = target;
         tick_in  = '0;
         qstep_in = '0;
         case (target)
            PH_START_HOLD:    dio_lvl_in = 1'b0;
            PH_BIT_CLK_LOW:   clk_lvl_in = 1'b0;
            PH_BIT_DATA:      dio_lvl_in = shift_in[0];
            PH_BIT_CLK_HIGH:  clk_lvl_in = 1'b1;
            PH_ACK_CLK_LOW: begin
               clk_lvl_in = 1'b0;
               dio_lvl_in = 1'b1;
            end
            PH_ACK_CLK_HIGH:  clk_lvl_in = 1'b1;
            PH_ACK_SAMPLE: begin
               sampled = 1'b1;
               if (!dio_sample) begin
                  dio_lvl_in = 1'b0;
               end
            end
            PH_STOP_CLK_LOW:  clk_lvl_in = 1'b0;
            PH_STOP_DIO_LOW:  dio_lvl_in = 1'b0;
            PH_STOP_CLK_HIGH: clk_lvl_in = 1'b1;
            PH_STOP_DIO_HIGH: dio_lvl_in = 1'b1;
            default:          phase_in   = PH_IDLE;
         endcase
      end
   end

   // result word for this cycle
   assign result.clk_release = clk_lvl_in;
   assign result.dio_release = dio_lvl_in;
   assign result.busy        = (phase_in != PH_IDLE);
   assign result.ack_valid   = sampled;
   assign result.ack_bit     = sampled & dio_sample;

   // sequencer state advances once per accepted word; the quarter register loads on every CSR write
   always_ff @(posedge clock) begin
      if (reset) begin
         quarter_ff <= QUARTER_RESET;
         phase_ff   <= PH_IDLE;
         bit_ff     <= '0;
         shift_ff   <= '0;
         tick_ff    <= '0;
         qstep_ff   <= '0;
         clk_lvl_ff <= 1'b1;
         dio_lvl_ff <= 1'b1;
      end else begin
         if (csr_wr_en) begin
            quarter_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff   <= phase_in;
            bit_ff     <= bit_in;
            shift_ff   <= shift_in;
            tick_ff    <= tick_in;
            qstep_ff   <= qstep_in;
            clk_lvl_ff <= clk_lvl_in;
            dio_lvl_ff <= dio_lvl_in;
         end
      end
   end

endmodule

`default_nettype wire
